### hdl/video_register_file_irq_dma_assert.svh
// Assertion macros shared by the checker.
`ifndef VIDEO_REGISTER_FILE_IRQ_DMA_ASSERT_SVH
`define VIDEO_REGISTER_FILE_IRQ_DMA_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define VRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define VRF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/vrf_pkg.sv
package vrf_pkg;

  // Beat kinds on the command port.
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_CYCLES = 2'd2,
    KIND_DMA    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [10:0] address;
    logic [15:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        frame_done;
    logic        draw_line;
    logic [7:0]  line_number;
    logic        dma_busy;
    logic [13:0] dma_address;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
  } status_t;

  localparam int SPRITE_COUNT_DEF = 256;
  localparam int TABLE_DEPTH      = 256;
  localparam int TABLE_AW         = 8;

  // Memory regions.
  localparam logic [10:0] ADDR_SCROLL   = 11'h100;
  localparam logic [10:0] ADDR_COMPRESS = 11'h200;
  localparam logic [10:0] ADDR_PALETTE  = 11'h300;
  localparam logic [10:0] ADDR_SPRITE   = 11'h400;

  // Register map.
  localparam logic [10:0] ADDR_LAYER_LO   = 11'h010;
  localparam logic [10:0] ADDR_LAYER_HI   = 11'h01B;
  localparam logic [10:0] ADDR_CMP_AMOUNT = 11'h01C;
  localparam logic [10:0] ADDR_CMP_OFFSET = 11'h01D;
  localparam logic [10:0] ADDR_SEG0       = 11'h020;
  localparam logic [10:0] ADDR_SEG1       = 11'h021;
  localparam logic [10:0] ADDR_SPR_SEG    = 11'h022;
  localparam logic [10:0] ADDR_BLEND      = 11'h02A;
  localparam logic [10:0] ADDR_FADE       = 11'h030;
  localparam logic [10:0] ADDR_LINE_MATCH = 11'h036;
  localparam logic [10:0] ADDR_COL_MATCH  = 11'h037;
  localparam logic [10:0] ADDR_SCANLINE   = 11'h038;
  localparam logic [10:0] ADDR_TV         = 11'h03C;
  localparam logic [10:0] ADDR_SPR_SET    = 11'h042;
  localparam logic [10:0] ADDR_LCD        = 11'h054;
  localparam logic [10:0] ADDR_IRQ_EN     = 11'h062;
  localparam logic [10:0] ADDR_IRQ_PEND   = 11'h063;
  localparam logic [10:0] ADDR_DMA_SRC    = 11'h070;
  localparam logic [10:0] ADDR_DMA_DST    = 11'h071;
  localparam logic [10:0] ADDR_DMA_LEN    = 11'h072;

  // Layer register slots for the two segment pointers.
  localparam logic [3:0] LAYER_SEG0 = 4'd6;
  localparam logic [3:0] LAYER_SEG1 = 4'd13;
  localparam int         LAYER_REGS = 14;
  localparam logic [3:0] LAYER_FIELDS = 4'd6;

  // Line timing.
  localparam logic [10:0] LINE_LEN_NTSC = 11'd1716;
  localparam logic [10:0] LINE_LEN_PAL  = 11'd1728;
  localparam logic [8:0]  LINES_NTSC    = 9'd262;
  localparam logic [8:0]  LINES_PAL     = 9'd312;
  localparam logic [8:0]  LAST_VISIBLE  = 9'd239;
  localparam logic [8:0]  VISIBLE_LINES = 9'd240;

  // Pending bit positions.
  localparam int PEND_VBLANK = 0;
  localparam int PEND_LINE   = 1;
  localparam int PEND_DMA    = 2;

  // Reset values.
  localparam logic [8:0]  CMP_AMOUNT_RST = 9'h020;
  localparam logic [15:0] TV_RST         = 16'h0020;
  localparam logic [8:0]  MATCH_RST      = 9'h1FF;

  // Write mask of a layer register field.
  function automatic logic [15:0] layer_mask(input logic [2:0] f);
    logic [15:0] m;
    case (f)
      3'd0:    m = 16'h01FF;
      3'd1:    m = 16'h00FF;
      3'd2:    m = 16'h3FFF;
      3'd3:    m = 16'h01FF;
      3'd4:    m = 16'h3FFF;
      3'd5:    m = 16'h3FFF;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

  // Write mask of a sprite word by its slot in the entry.
  function automatic logic [15:0] sprite_mask(input logic [1:0] w);
    logic [15:0] m;
    case (w)
      2'd0:    m = 16'hFFFF;
      2'd1:    m = 16'h01FF;
      2'd2:    m = 16'h01FF;
      default: m = 16'h7FFF;
    endcase
    return m;
  endfunction

endpackage

### hdl/video_register_file_irq_dma.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------
// command   | in        | start && !busy          | item_i (vrf_pkg::item_t)
// result    | out       | done_o, one cycle       | result_o (vrf_pkg::result_t)
// config    | in        | cfg_we_i                | cfg_wdata_i (video_pal)
//
// A beat has an accept edge, which loads the memory read registers, and an
// execute cycle, which updates state. The result strobe follows for one cycle,
// and the next beat can be accepted at the edge that ends it.
// After reset a clearing sweep zeroes all memories, one row per cycle, with
// busy high; config writes still land.
// The receiver cannot stall; results are never held back.
module video_register_file_irq_dma #(
  parameter int SPRITE_COUNT = vrf_pkg::SPRITE_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vrf_pkg::item_t   item_i,
  output logic             done_o,
  output vrf_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  vrf_pkg::cmd_t    cmd;
  vrf_pkg::status_t status;

  vrf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  vrf_dp #(
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

endmodule

### hdl/vrf_ctrl.sv
module vrf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  vrf_pkg::status_t status_i,
  output vrf_pkg::cmd_t    cmd_o,
  output logic             busy,
  output logic             done_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  // State and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o.clear   = (state_q == ST_CLEAR);
    cmd_o.capture = (state_q == ST_IDLE) && start;
    cmd_o.exec    = (state_q == ST_EXEC);
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

### hdl/vrf_dp.sv
module vrf_dp #(
  parameter int SPRITE_COUNT = vrf_pkg::SPRITE_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vrf_pkg::cmd_t    cmd_i,
  output vrf_pkg::status_t status_o,
  input  vrf_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output vrf_pkg::result_t result_o
);

  localparam int SPR_DEPTH = SPRITE_COUNT * 4;
  localparam int SPR_AW    = $clog2(SPR_DEPTH);
  localparam int CLR_DEPTH = (SPR_DEPTH > vrf_pkg::TABLE_DEPTH) ? SPR_DEPTH
                                                                : vrf_pkg::TABLE_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);
  localparam int TAW       = vrf_pkg::TABLE_AW;

  // Memories.
  logic [15:0] spr_mem [SPR_DEPTH];
  logic [15:0] pal_mem [vrf_pkg::TABLE_DEPTH];
  logic [8:0]  scr_mem [vrf_pkg::TABLE_DEPTH];
  logic [15:0] cmp_mem [vrf_pkg::TABLE_DEPTH];
  logic [15:0] spr_rd_q, pal_rd_q, cmp_rd_q;
  logic [8:0]  scr_rd_q;

  // Registers.
  logic              pal_q;
  vrf_pkg::item_t    item_q;
  vrf_pkg::result_t  res_q, res_d;
  logic [CLR_AW-1:0] clr_q;
  logic [15:0] layer_q [vrf_pkg::LAYER_REGS];
  logic [15:0] layer_d [vrf_pkg::LAYER_REGS];
  logic [15:0] spr_seg_q, spr_seg_d, tv_q, tv_d;
  logic [1:0]  blend_q, blend_d, spr_set_q, spr_set_d;
  logic [8:0]  cmp_amt_q, cmp_amt_d, lmatch_q, lmatch_d, cmatch_q, cmatch_d;
  logic [12:0] cmp_off_q, cmp_off_d;
  logic [7:0]  fade_q, fade_d;
  logic [5:0]  lcd_q, lcd_d;
  logic [2:0]  irq_en_q, irq_en_d, pend_q, pend_d;
  logic [13:0] src_q, src_d;
  logic [9:0]  dst_q, dst_d, rem_q, rem_d;
  logic [8:0]  scan_q, scan_d;
  logic [10:0] acc_q, acc_d;

  // Memory write ports.
  logic              spr_we, pal_we, scr_we, cmp_we;
  logic [SPR_AW-1:0] spr_wa;
  logic [15:0]       spr_wd;

  // Decode helpers.
  logic [10:0] a;
  logic [15:0] v;
  logic [3:0]  k, lidx;
  logic [2:0]  lfield;
  logic        a_spr_ok, dst_ok;
  logic [15:0] rd;
  logic [10:0] line_len, cyc, rem_cyc;
  logic [8:0]  total;
  logic [11:0] sum, over;

  assign a        = item_q.address;
  assign v        = item_q.data;
  assign k        = a[3:0];
  assign lidx     = (k < vrf_pkg::LAYER_FIELDS) ? k : k + 4'd1;
  assign lfield   = (k < vrf_pkg::LAYER_FIELDS) ? k[2:0] : 3'(k - vrf_pkg::LAYER_FIELDS);
  assign a_spr_ok = {1'b0, a[9:0]} < 11'(SPR_DEPTH);
  assign dst_ok   = {1'b0, dst_q} < 11'(SPR_DEPTH);

  assign status_o.clear_last = (clr_q == CLR_AW'(CLR_DEPTH - 1));

  // Bus read mux.
  always_comb begin
    rd = '0;
    if (a >= vrf_pkg::ADDR_SPRITE) begin
      rd = a_spr_ok ? spr_rd_q : 16'd0;
    end else if (a >= vrf_pkg::ADDR_PALETTE) begin
      rd = pal_rd_q;
    end else if (a >= vrf_pkg::ADDR_COMPRESS) begin
      rd = cmp_rd_q;
    end else if (a >= vrf_pkg::ADDR_SCROLL) begin
      rd = 16'(scr_rd_q);
    end else begin
      case (a) inside
        [vrf_pkg::ADDR_LAYER_LO:vrf_pkg::ADDR_LAYER_HI]: rd = layer_q[lidx];
        vrf_pkg::ADDR_CMP_AMOUNT: rd = 16'(cmp_amt_q);
        vrf_pkg::ADDR_CMP_OFFSET: rd = 16'(cmp_off_q);
        vrf_pkg::ADDR_SEG0:       rd = layer_q[vrf_pkg::LAYER_SEG0];
        vrf_pkg::ADDR_SEG1:       rd = layer_q[vrf_pkg::LAYER_SEG1];
        vrf_pkg::ADDR_SPR_SEG:    rd = spr_seg_q;
        vrf_pkg::ADDR_BLEND:      rd = 16'(blend_q);
        vrf_pkg::ADDR_FADE:       rd = 16'(fade_q);
        vrf_pkg::ADDR_LINE_MATCH: rd = 16'(lmatch_q);
        vrf_pkg::ADDR_COL_MATCH:  rd = 16'(cmatch_q);
        vrf_pkg::ADDR_SCANLINE:   rd = 16'(scan_q);
        vrf_pkg::ADDR_TV:         rd = tv_q;
        vrf_pkg::ADDR_SPR_SET:    rd = 16'(spr_set_q);
        vrf_pkg::ADDR_LCD:        rd = 16'(lcd_q);
        vrf_pkg::ADDR_IRQ_EN:     rd = 16'(irq_en_q);
        vrf_pkg::ADDR_IRQ_PEND:   rd = 16'(pend_q);
        vrf_pkg::ADDR_DMA_SRC:    rd = 16'(src_q);
        vrf_pkg::ADDR_DMA_DST:    rd = 16'(dst_q);
        vrf_pkg::ADDR_DMA_LEN:    rd = 16'(rem_q);
        default:                  rd = '0;
      endcase
    end
  end

  // Line clock arithmetic.
  always_comb begin
    line_len = pal_q ? vrf_pkg::LINE_LEN_PAL : vrf_pkg::LINE_LEN_NTSC;
    total    = pal_q ? vrf_pkg::LINES_PAL : vrf_pkg::LINES_NTSC;
    cyc      = (v > {5'd0, line_len}) ? line_len : v[10:0];
    sum      = {1'b0, acc_q} + {1'b0, cyc};
    over     = sum - {1'b0, line_len};
    rem_cyc  = (over >= {1'b0, line_len}) ? line_len - 11'd1 : over[10:0];
  end

  // Next state for one beat.
  always_comb begin
    layer_d   = layer_q;
    spr_seg_d = spr_seg_q;
    tv_d      = tv_q;
    blend_d   = blend_q;
    spr_set_d = spr_set_q;
    cmp_amt_d = cmp_amt_q;
    lmatch_d  = lmatch_q;
    cmatch_d  = cmatch_q;
    cmp_off_d = cmp_off_q;
    fade_d    = fade_q;
    lcd_d     = lcd_q;
    irq_en_d  = irq_en_q;
    pend_d    = pend_q;
    src_d     = src_q;
    dst_d     = dst_q;
    rem_d     = rem_q;
    scan_d    = scan_q;
    acc_d     = acc_q;
    spr_we    = 1'b0;
    pal_we    = 1'b0;
    scr_we    = 1'b0;
    cmp_we    = 1'b0;
    spr_wa    = a[SPR_AW-1:0];
    spr_wd    = v & vrf_pkg::sprite_mask(a[1:0]);
    res_d     = '0;

    if (cmd_i.exec) begin
      case (item_q.kind)
        vrf_pkg::KIND_READ: begin
          res_d.read_data = rd;
        end
        vrf_pkg::KIND_WRITE: begin
          if (a >= vrf_pkg::ADDR_SPRITE) begin
            spr_we = a_spr_ok;
          end else if (a >= vrf_pkg::ADDR_PALETTE) begin
            pal_we = 1'b1;
          end else if (a >= vrf_pkg::ADDR_COMPRESS) begin
            cmp_we = 1'b1;
          end else if (a >= vrf_pkg::ADDR_SCROLL) begin
            scr_we = 1'b1;
          end else begin
            case (a) inside
              [vrf_pkg::ADDR_LAYER_LO:vrf_pkg::ADDR_LAYER_HI]:
                layer_d[lidx] = v & vrf_pkg::layer_mask(lfield);
              vrf_pkg::ADDR_CMP_AMOUNT: cmp_amt_d = v[8:0];
              vrf_pkg::ADDR_CMP_OFFSET: cmp_off_d = v[12:0];
              vrf_pkg::ADDR_SEG0:       layer_d[vrf_pkg::LAYER_SEG0] = v;
              vrf_pkg::ADDR_SEG1:       layer_d[vrf_pkg::LAYER_SEG1] = v;
              vrf_pkg::ADDR_SPR_SEG:    spr_seg_d = v;
              vrf_pkg::ADDR_BLEND:      blend_d = v[1:0];
              vrf_pkg::ADDR_FADE:       fade_d = v[7:0];
              vrf_pkg::ADDR_LINE_MATCH: lmatch_d = v[8:0];
              vrf_pkg::ADDR_COL_MATCH:  cmatch_d = v[8:0];
              vrf_pkg::ADDR_TV:         tv_d = v;
              vrf_pkg::ADDR_SPR_SET:    spr_set_d = v[1:0];
              vrf_pkg::ADDR_LCD:        lcd_d = v[5:0];
              vrf_pkg::ADDR_IRQ_EN:     irq_en_d = v[2:0];
              vrf_pkg::ADDR_IRQ_PEND:   pend_d = pend_q & ~v[2:0];
              vrf_pkg::ADDR_DMA_SRC:    src_d = v[13:0];
              vrf_pkg::ADDR_DMA_DST:    dst_d = v[9:0];
              vrf_pkg::ADDR_DMA_LEN: begin
                rem_d = v[9:0];
                // zero length finishes at once
                if (v[9:0] == 10'd0 && irq_en_q[vrf_pkg::PEND_DMA])
                  pend_d[vrf_pkg::PEND_DMA] = 1'b1;
              end
              default: ;
            endcase
          end
        end
        vrf_pkg::KIND_CYCLES: begin
          if (sum >= {1'b0, line_len}) begin
            acc_d = rem_cyc;
            if (scan_q == lmatch_q && irq_en_q[vrf_pkg::PEND_LINE])
              pend_d[vrf_pkg::PEND_LINE] = 1'b1;
            if (scan_q < vrf_pkg::VISIBLE_LINES) begin
              res_d.draw_line   = 1'b1;
              res_d.line_number = scan_q[7:0];
              if (scan_q == vrf_pkg::LAST_VISIBLE) begin
                pend_d[vrf_pkg::PEND_VBLANK] = 1'b1;
                res_d.frame_done             = 1'b1;
              end
              scan_d = scan_q + 9'd1;
            end else if (scan_q >= total - 9'd1) begin
              pend_d[vrf_pkg::PEND_VBLANK] = 1'b0;
              scan_d = '0;
            end else begin
              scan_d = scan_q + 9'd1;
            end
          end else begin
            acc_d = sum[10:0];
          end
        end
        vrf_pkg::KIND_DMA: begin
          if (rem_q != 10'd0) begin
            spr_we = dst_ok;
            spr_wa = dst_q[SPR_AW-1:0];
            spr_wd = v & vrf_pkg::sprite_mask(dst_q[1:0]);
            dst_d  = dst_q + 10'd1;
            src_d  = src_q + 14'd1;
            rem_d  = rem_q - 10'd1;
            if (rem_q == 10'd1 && irq_en_q[vrf_pkg::PEND_DMA])
              pend_d[vrf_pkg::PEND_DMA] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res_d.irq         = |(irq_en_d & pend_d);
    res_d.dma_busy    = (rem_d != 10'd0);
    res_d.dma_address = src_d;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q     <= 1'b0;
      clr_q     <= '0;
      for (int i = 0; i < vrf_pkg::LAYER_REGS; i++) layer_q[i] <= '0;
      spr_seg_q <= '0;
      tv_q      <= vrf_pkg::TV_RST;
      blend_q   <= '0;
      spr_set_q <= '0;
      cmp_amt_q <= vrf_pkg::CMP_AMOUNT_RST;
      lmatch_q  <= vrf_pkg::MATCH_RST;
      cmatch_q  <= vrf_pkg::MATCH_RST;
      cmp_off_q <= '0;
      fade_q    <= '0;
      lcd_q     <= '0;
      irq_en_q  <= '0;
      pend_q    <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      rem_q     <= '0;
      scan_q    <= '0;
      acc_q     <= '0;
    end else begin
      if (cfg_we_i) pal_q <= cfg_wdata_i;
      if (cmd_i.clear) clr_q <= clr_q + CLR_AW'(1);
      layer_q   <= layer_d;
      spr_seg_q <= spr_seg_d;
      tv_q      <= tv_d;
      blend_q   <= blend_d;
      spr_set_q <= spr_set_d;
      cmp_amt_q <= cmp_amt_d;
      lmatch_q  <= lmatch_d;
      cmatch_q  <= cmatch_d;
      cmp_off_q <= cmp_off_d;
      fade_q    <= fade_d;
      lcd_q     <= lcd_d;
      irq_en_q  <= irq_en_d;
      pend_q    <= pend_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      rem_q     <= rem_d;
      scan_q    <= scan_d;
      acc_q     <= acc_d;
    end
  end

  // Beat capture and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.exec) res_q <= res_d;
  end

  // Memories: clearing sweep, writes, registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if ({1'b0, clr_q} < (CLR_AW + 1)'(SPR_DEPTH)) spr_mem[clr_q[SPR_AW-1:0]] <= '0;
      pal_mem[clr_q[TAW-1:0]] <= '0;
      scr_mem[clr_q[TAW-1:0]] <= '0;
      cmp_mem[clr_q[TAW-1:0]] <= '0;
    end else begin
      if (spr_we) spr_mem[spr_wa] <= spr_wd;
      if (pal_we) pal_mem[a[TAW-1:0]] <= v;
      if (scr_we) scr_mem[a[TAW-1:0]] <= v[8:0];
      if (cmp_we) cmp_mem[a[TAW-1:0]] <= v;
    end
    if (cmd_i.capture) begin
      spr_rd_q <= spr_mem[item_i.address[SPR_AW-1:0]];
      pal_rd_q <= pal_mem[item_i.address[TAW-1:0]];
      scr_rd_q <= scr_mem[item_i.address[TAW-1:0]];
      cmp_rd_q <= cmp_mem[item_i.address[TAW-1:0]];
    end
  end

  assign result_o = res_q;

endmodule

### hdl/vrf_checker.sv
`include "video_register_file_irq_dma_assert.svh"

module vrf_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input vrf_pkg::result_t result_o
);

  // An accepted beat yields its result strobe once the execute state is done.
  `VRF_ASSERT(a_result_after_accept, start && !busy |-> ##2 done_o, "result beat missing")

  // Results never come on consecutive cycles.
  `VRF_ASSERT(a_no_double_result, done_o |-> !$past(done_o), "result beat repeated")

  // Frame end only with the last visible line drawn.
  `VRF_ASSERT(a_frame_on_last_line, done_o && result_o.frame_done |-> result_o.draw_line && result_o.line_number == 8'd239, "frame end without line 239")

  // Clearing sweep keeps the block busy after reset.
  `VRF_ASSERT_RST(a_busy_after_reset, !rst_ni |=> busy, "not busy after reset")

endmodule

bind video_register_file_irq_dma vrf_checker u_vrf_checker (.*);
